@@ design/b2da_pkg.sv @@
package b2da_pkg;

    localparam int VALUE_W    = 64;
    localparam int BCD_DIGITS = 20;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int BITCNT_W   = $clog2(VALUE_W);
    localparam int DIGCNT_W   = $clog2(BCD_DIGITS);
    localparam int CHAR_W     = 8;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_NORM,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic digit_shift;
        logic sel_sign;
    } dp_cmd_t;

    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic ndig_zero;
        logic neg;
    } dp_status_t;

endpackage

@@ design/b2da_datapath.sv @@
module b2da_datapath
    import b2da_pkg::*;
(
    input  logic                aclk,
    input  logic [VALUE_W-1:0]  s_value,
    input  logic                s_is_signed,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    output logic [CHAR_W-1:0]   m_character,
    output logic                m_last
);

    logic [VALUE_W-1:0]  mag_reg, mag_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [BITCNT_W-1:0] bitcnt_reg, bitcnt_next;
    logic [DIGCNT_W-1:0] ndig_reg, ndig_next;
    logic                neg_reg, neg_next;
    logic [BCD_W-1:0]    bcd_adj;
    logic                in_neg;

    assign in_neg = s_is_signed && s_value[VALUE_W-1];

    always_comb begin
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (bcd_reg[4*d +: 4] >= 4'd5) begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end else begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
    end

    always_comb begin
        mag_next    = mag_reg;
        bcd_next    = bcd_reg;
        bitcnt_next = bitcnt_reg;
        ndig_next   = ndig_reg;
        neg_next    = neg_reg;
        if (cmd.load) begin
            mag_next    = in_neg ? (VALUE_W'(0) - s_value) : s_value;
            bcd_next    = '0;
            bitcnt_next = '0;
            ndig_next   = DIGCNT_W'(BCD_DIGITS - 1);
            neg_next    = in_neg;
        end else if (cmd.conv_step) begin
            {bcd_next, mag_next} = {bcd_adj[BCD_W-2:0], mag_reg, 1'b0};
            bitcnt_next          = bitcnt_reg + BITCNT_W'(1);
        end else if (cmd.digit_shift) begin
            bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
            ndig_next = ndig_reg - DIGCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg    <= mag_next;
        bcd_reg    <= bcd_next;
        bitcnt_reg <= bitcnt_next;
        ndig_reg   <= ndig_next;
        neg_reg    <= neg_next;
    end

    assign status.conv_done = (bitcnt_reg == BITCNT_W'(VALUE_W - 1));
    assign status.top_zero  = (bcd_reg[BCD_W-1 -: 4] == 4'd0);
    assign status.ndig_zero = (ndig_reg == '0);
    assign status.neg       = neg_reg;

    assign m_character = cmd.sel_sign ? CHAR_MINUS
                                      : (CHAR_ZERO | {4'd0, bcd_reg[BCD_W-1 -: 4]});
    assign m_last      = !cmd.sel_sign && status.ndig_zero;

endmodule

@@ design/b2da_ctrl.sv @@
module b2da_ctrl
    import b2da_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_CONV;
            end
            ST_CONV: begin
                if (status.conv_done) state_next = ST_NORM;
            end
            ST_NORM: begin
                if (!status.top_zero || status.ndig_zero) begin
                    state_next = status.neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (m_ready) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_ready && status.ndig_zero) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready         = 1'b0;
        m_valid         = 1'b0;
        cmd             = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_CONV: begin
                cmd.conv_step = 1'b1;
            end
            ST_NORM: begin
                cmd.digit_shift = status.top_zero && !status.ndig_zero;
            end
            ST_SIGN: begin
                m_valid      = 1'b1;
                cmd.sel_sign = 1'b1;
            end
            ST_EMIT: begin
                m_valid         = 1'b1;
                cmd.digit_shift = m_ready && !status.ndig_zero;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while a result is pending");

    a_load_starts_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_CONV))
        else $error("conversion did not start after load");

    a_conv_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV && status.conv_done) |=> (state_reg == ST_NORM))
        else $error("conversion did not end after last bit");

    a_last_frees_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && m_ready && status.ndig_zero) |=> s_ready)
        else $error("block not idle after last character");

endmodule

@@ design/binary_to_decimal_ascii.sv @@
// Binary to decimal ASCII converter, 64 bits.
//
// Input channel (s_valid/s_ready): one transaction carries s_value and
// s_is_signed. With s_is_signed high and bit 63 set the value is negative.
// Output channel (m_valid/m_ready): one transaction per character, most
// significant first; '-' leads negative values, m_last marks the final digit.
// Zero gives the single character '0'.
//
// After a load, the value is converted by one shift-add-3 step per input
// bit (one input bit per cycle); leading zero digits are then dropped (one
// digit per cycle) until a nonzero digit or the last digit is at the top,
// after which the first character is presented. A new character follows
// each one taken. One number is handled at a time: s_ready is high only
// while idle.
// If the receiver stalls, the current character holds until taken.
// Reset (aresetn low, synchronous) returns the controller to idle and
// drops any conversion in progress.
module binary_to_decimal_ascii
    import b2da_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [VALUE_W-1:0]  s_value,
    input  logic                s_is_signed,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CHAR_W-1:0]   m_character,
    output logic                m_last
);

    dp_cmd_t    cmd;
    dp_status_t status;

    b2da_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    b2da_datapath u_datapath (
        .aclk        (aclk),
        .s_value     (s_value),
        .s_is_signed (s_is_signed),
        .cmd         (cmd),
        .status      (status),
        .m_character (m_character),
        .m_last      (m_last)
    );

endmodule

@@ tb/binary_to_decimal_ascii_tb.sv @@
module binary_to_decimal_ascii_tb
    import b2da_pkg::*;
();

    localparam int RANDOM_ITEMS = 187;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int DRAIN_CYCLES = 120;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [VALUE_W-1:0]  s_value;
    logic                s_is_signed;
    logic                m_valid;
    logic                m_ready;
    logic [CHAR_W-1:0]   m_character;
    logic                m_last;

    logic [CHAR_W-1:0]   text_char_q[$];
    logic                text_last_q[$];

    logic [VALUE_W-1:0]  row_value[$];
    logic                row_signed[$];
    string               row_text[$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  no_idle        = 1'b0;

    binary_to_decimal_ascii dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .s_is_signed (s_is_signed),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("binary_to_decimal_ascii test failed");
            $finish;
        end
    end

    function automatic void predict_decimal_text(input logic [VALUE_W-1:0] v, input logic sg);
        logic [VALUE_W-1:0] mag;
        logic [CHAR_W-1:0]  digits[$];
        logic               neg;
        neg = sg && v[VALUE_W-1];
        mag = neg ? (64'd0 - v) : v;
        do begin
            digits.push_front(CHAR_ZERO + CHAR_W'(mag % 64'd10));
            mag = mag / 64'd10;
        end while (mag != 64'd0);
        if (neg) begin
            text_char_q.push_back(CHAR_MINUS);
            text_last_q.push_back(1'b0);
        end
        foreach (digits[i]) begin
            text_char_q.push_back(digits[i]);
            text_last_q.push_back(i == digits.size() - 1);
        end
    endfunction

    function automatic void push_typed_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            text_char_q.push_back(s[i]);
            text_last_q.push_back(i == s.len() - 1);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        logic [VALUE_W-1:0] full;
        logic [VALUE_W-1:0] pow;
        int                 nbits;
        full = {$urandom, $urandom};
        case ($urandom_range(0, 9)) inside
            [0:3]: begin
                return full;
            end
            [4:5]: begin
                nbits = $urandom_range(1, 64);
                return (nbits == 64) ? full : full & ((64'd1 << nbits) - 64'd1);
            end
            6: begin
                pow = 64'd1;
                repeat ($urandom_range(0, 19)) pow = pow * 64'd10;
                return pow + 64'($urandom_range(0, 2)) - 64'd1;
            end
            7: begin
                return 64'd0 - 64'($urandom_range(0, 1000));
            end
            8: begin
                if ($urandom_range(0, 1))
                    return {1'b1, 63'd0} + 64'($urandom_range(0, 3));
                return {1'b0, {63{1'b1}}} - 64'($urandom_range(0, 3));
            end
            default: begin
                return 64'($urandom_range(0, 99));
            end
        endcase
    endfunction

    task automatic add_row(input logic [VALUE_W-1:0] v, input logic sg, input string s);
        row_value.push_back(v);
        row_signed.push_back(sg);
        row_text.push_back(s);
    endtask

    // Caller's s_valid may still be high from the previous transaction.
    task automatic send_number(input logic [VALUE_W-1:0] v, input logic sg, input string s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_value     <= v;
        s_is_signed <= sg;
        do @(posedge aclk); while (!s_ready);
        if (s.len() > 0)
            push_typed_text(s);
        else
            predict_decimal_text(v, sg);
    endtask

    always @(posedge aclk) begin : check_characters
        logic [CHAR_W-1:0] want_char;
        logic              want_last;
        if (aresetn && m_valid && m_ready) begin
            if (text_char_q.size() == 0) begin
                $display("%0t: unexpected character expected none, actual %h last %b",
                         $time, m_character, m_last);
                mismatch_count++;
            end else begin
                want_char = text_char_q.pop_front();
                want_last = text_last_q.pop_front();
                if (m_character !== want_char) begin
                    $display("%0t: character expected %h, actual %h",
                             $time, want_char, m_character);
                    mismatch_count++;
                end
                if (m_last !== want_last) begin
                    $display("%0t: last expected %b, actual %b", $time, want_last, m_last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (no_idle) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    end

    initial begin
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_value     <= '0;
        s_is_signed <= 1'b0;

        add_row(64'd0,                     1'b0, "0");
        add_row(64'd0,                     1'b1, "0");
        add_row(64'hFFFF_FFFF_FFFF_FFFF,   1'b0, "18446744073709551615");
        add_row(64'hFFFF_FFFF_FFFF_FFFF,   1'b1, "-1");
        add_row(64'h8000_0000_0000_0000,   1'b1, "-9223372036854775808");
        add_row(64'h8000_0000_0000_0000,   1'b0, "9223372036854775808");
        add_row(64'h7FFF_FFFF_FFFF_FFFF,   1'b1, "9223372036854775807");
        add_row(64'hFFFF_FFFF_FFFF_FFF6,   1'b1, "-10");
        add_row(64'd9,                     1'b0, "9");
        add_row(64'd10,                    1'b1, "10");
        add_row(64'd10000000000000000000,  1'b0, "10000000000000000000");
        add_row(64'd1000000000000000000,   1'b1, "1000000000000000000");
        add_row(64'd9999999999999999999,   1'b0, "");
        add_row(64'd999999999999999999,    1'b1, "");
        add_row(64'd100000000,             1'b0, "");
        add_row(64'd99999999,              1'b1, "");
        add_row(64'h0000_0000_7FFF_FFFF,   1'b0, "");
        add_row(64'h0000_0000_FFFF_FFFF,   1'b1, "");
        add_row(64'h0000_0001_0000_0000,   1'b0, "");
        add_row(64'h8000_0000_0000_0001,   1'b1, "");
        add_row(64'hFFFF_FFFF_7FFF_FFFF,   1'b1, "");
        add_row(64'hAAAA_5555_AAAA_5555,   1'b0, "");
        add_row(64'h5555_AAAA_5555_AAAA,   1'b1, "");

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (row_value[i])
            send_number(row_value[i], row_signed[i], row_text[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= 60 && n < 100);
            send_number(rand_value(), 1'($urandom_range(0, 1)), "");
        end
        no_idle = 1'b0;
        s_valid <= 1'b0;

        while (text_char_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("binary_to_decimal_ascii test passed");
        else
            $display("binary_to_decimal_ascii test failed");
        $finish;
    end

endmodule

@@ sim.f @@
design/b2da_pkg.sv
design/b2da_datapath.sv
design/b2da_ctrl.sv
design/binary_to_decimal_ascii.sv
tb/binary_to_decimal_ascii_tb.sv
